[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

[src/bwwp_pkg.sv]
// ----------------------------------------------------------------------------
// Bus write watchpoint package
// Request codes, beat payload types and table sizing for the watchpoint unit.
// ----------------------------------------------------------------------------
package bwwp_pkg;

    localparam int WATCH_SLOTS = 8;
    localparam int CNT_W       = $clog2(WATCH_SLOTS + 1);

    typedef enum logic [2:0] {
        REQ_SET         = 3'd0,
        REQ_CLEAR       = 3'd1,
        REQ_CLEAR_ALL   = 3'd2,
        REQ_BUS_WRITE   = 3'd3,
        REQ_INSTR_BEGIN = 3'd4,
        REQ_INSTR_END   = 3'd5,
        REQ_READ_SLOT   = 3'd6
    } req_type_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] address;
        logic [15:0] length;
        logic [7:0]  data_value;
        logic [15:0] pc_value;
        logic [2:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] hit_base;
        logic [15:0] hit_writer_pc;
        logic        set_rejected;
        logic        entry_valid;
        logic [15:0] entry_base;
        logic [15:0] entry_length;
        logic [7:0]  entry_last_value;
        logic [15:0] entry_last_pc;
        logic        entry_fired;
    } out_item_t;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] length;
        logic [7:0]  last_byte;
        logic [15:0] last_pc;
        logic        fired;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pending_hit;
    } table_status_t;

endpackage

[src/bwwp_in_stage.sv]
// ----------------------------------------------------------------------------
// Watchpoint input stage
// Registers one request beat and holds it until the execute stage takes it.
// ----------------------------------------------------------------------------
module bwwp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bwwp_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output bwwp_pkg::in_item_t item
);

    logic               valid_reg, valid_next;
    bwwp_pkg::in_item_t item_reg;

    // Take a new beat when empty or when the held one moves on
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until replaced
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/bwwp_table.sv]
// ----------------------------------------------------------------------------
// Watchpoint table
// Holds the ordered range table and the per-instruction hit state, applies
// one request per cycle while exec is high and forms its result.
// ----------------------------------------------------------------------------
module bwwp_table (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    exec,
    input  bwwp_pkg::in_item_t      item,
    output bwwp_pkg::out_item_t     result,
    output bwwp_pkg::table_status_t status
);

    bwwp_pkg::entry_t tbl_reg [bwwp_pkg::WATCH_SLOTS];
    bwwp_pkg::entry_t tbl_next[bwwp_pkg::WATCH_SLOTS];
    bwwp_pkg::entry_t packed_tbl[bwwp_pkg::WATCH_SLOTS];

    logic [bwwp_pkg::CNT_W-1:0] count_reg, count_next;
    logic [15:0]                instr_pc_reg, instr_pc_next;
    logic                       instr_hit_reg, instr_hit_next;
    logic [15:0]                hit_base_reg, hit_base_next;

    logic [bwwp_pkg::WATCH_SLOTS-1:0] keep;
    logic [bwwp_pkg::WATCH_SLOTS-1:0] match;
    logic [bwwp_pkg::CNT_W-1:0]       pos [bwwp_pkg::WATCH_SLOTS];
    logic [bwwp_pkg::CNT_W-1:0]       kept_cnt;
    logic [15:0]                      first_base;

    // Mark surviving entries and their compacted positions
    always_comb begin
        kept_cnt = '0;
        for (int i = 0; i < bwwp_pkg::WATCH_SLOTS; i++) begin
            keep[i] = (i < int'(count_reg)) && (tbl_reg[i].base != item.address);
            pos[i]  = kept_cnt;
            kept_cnt = kept_cnt + bwwp_pkg::CNT_W'(keep[i]);
        end
    end

    // Close up the table over dropped entries
    always_comb begin
        for (int j = 0; j < bwwp_pkg::WATCH_SLOTS; j++) begin
            packed_tbl[j] = tbl_reg[j];
            for (int i = 0; i < bwwp_pkg::WATCH_SLOTS; i++) begin
                if (keep[i] && (int'(pos[i]) == j)) begin
                    packed_tbl[j] = tbl_reg[i];
                end
            end
        end
    end

    // Range compare for each live entry; end is 17 bits so it never wraps
    always_comb begin
        first_base = '0;
        for (int i = 0; i < bwwp_pkg::WATCH_SLOTS; i++) begin
            match[i] = (i < int'(count_reg))
                && (item.address >= tbl_reg[i].base)
                && ({1'b0, item.address} < ({1'b0, tbl_reg[i].base}
                                            + {1'b0, tbl_reg[i].length}));
        end
        for (int i = bwwp_pkg::WATCH_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                first_base = tbl_reg[i].base;
            end
        end
    end

    // Apply the request and form its result
    always_comb begin
        tbl_next       = tbl_reg;
        count_next     = count_reg;
        instr_pc_next  = instr_pc_reg;
        instr_hit_next = instr_hit_reg;
        hit_base_next  = hit_base_reg;
        result         = '0;

        case (item.req_type)
            bwwp_pkg::REQ_SET: begin
                if (item.length != '0) begin
                    tbl_next   = packed_tbl;
                    count_next = kept_cnt;
                    if (int'(kept_cnt) >= bwwp_pkg::WATCH_SLOTS) begin
                        result.set_rejected = 1'b1;
                    end else begin
                        for (int j = 0; j < bwwp_pkg::WATCH_SLOTS; j++) begin
                            if (int'(kept_cnt) == j) begin
                                tbl_next[j].base      = item.address;
                                tbl_next[j].length    = item.length;
                                tbl_next[j].last_byte = '0;
                                tbl_next[j].last_pc   = '0;
                                tbl_next[j].fired     = 1'b0;
                            end
                        end
                        count_next = kept_cnt + bwwp_pkg::CNT_W'(1);
                    end
                end
            end
            bwwp_pkg::REQ_CLEAR: begin
                tbl_next   = packed_tbl;
                count_next = kept_cnt;
            end
            bwwp_pkg::REQ_CLEAR_ALL: begin
                count_next = '0;
            end
            bwwp_pkg::REQ_BUS_WRITE: begin
                for (int i = 0; i < bwwp_pkg::WATCH_SLOTS; i++) begin
                    if (match[i]) begin
                        tbl_next[i].last_byte = item.data_value;
                        tbl_next[i].last_pc   = instr_pc_reg;
                        tbl_next[i].fired     = 1'b1;
                    end
                end
                if (!instr_hit_reg && (|match)) begin
                    instr_hit_next = 1'b1;
                    hit_base_next  = first_base;
                end
            end
            bwwp_pkg::REQ_INSTR_BEGIN: begin
                instr_pc_next  = item.pc_value;
                instr_hit_next = 1'b0;
                hit_base_next  = '0;
            end
            bwwp_pkg::REQ_INSTR_END: begin
                if (instr_hit_reg) begin
                    result.hit           = 1'b1;
                    result.hit_base      = hit_base_reg;
                    result.hit_writer_pc = instr_pc_reg;
                end
            end
            bwwp_pkg::REQ_READ_SLOT: begin
                for (int i = 0; i < bwwp_pkg::WATCH_SLOTS; i++) begin
                    if ((i < int'(count_reg)) && (int'(item.slot_index) == i)) begin
                        result.entry_valid      = 1'b1;
                        result.entry_base       = tbl_reg[i].base;
                        result.entry_length     = tbl_reg[i].length;
                        result.entry_last_value = tbl_reg[i].last_byte;
                        result.entry_last_pc    = tbl_reg[i].last_pc;
                        result.entry_fired      = tbl_reg[i].fired;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            instr_pc_reg  <= '0;
            instr_hit_reg <= 1'b0;
            hit_base_reg  <= '0;
        end else if (exec) begin
            count_reg     <= count_next;
            instr_pc_reg  <= instr_pc_next;
            instr_hit_reg <= instr_hit_next;
            hit_base_reg  <= hit_base_next;
        end
    end

    // Entry contents; only entries below the count are ever read
    always_ff @(posedge aclk) begin
        if (exec) begin
            tbl_reg <= tbl_next;
        end
    end

    assign status.count       = count_reg;
    assign status.pending_hit = instr_hit_reg;

endmodule

[src/bwwp_out_stage.sv]
// ----------------------------------------------------------------------------
// Watchpoint output stage
// Registers one result beat and holds it until the consumer takes it.
// ----------------------------------------------------------------------------
module bwwp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  bwwp_pkg::out_item_t load_item,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output bwwp_pkg::out_item_t m_item
);

    logic                valid_reg, valid_next;
    bwwp_pkg::out_item_t item_reg;

    // Free when empty or when the held beat leaves this cycle
    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= load_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

[src/bus_write_watchpoint_unit_core.sv]
// ----------------------------------------------------------------------------
// Bus write watchpoint unit
// Ordered table of address-range watchpoints with per-instruction hit report.
// ----------------------------------------------------------------------------
// Every request beat gives exactly one result beat, in order. A beat is
// registered on entry, executed against the watchpoint table once the
// result register has room, and registered again on the way out; one
// request is taken every cycle while the result side keeps up. The table
// update in the execute stage (compaction, eight range compares and the
// first-match pick) is combinational. Results that the caller does not
// drive read as zero.
`include "assert_macros.svh"

module bus_write_watchpoint_unit_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bwwp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bwwp_pkg::out_item_t m_item
);

    logic                    item_valid;
    bwwp_pkg::in_item_t      item;
    logic                    room;
    logic                    advance;
    bwwp_pkg::out_item_t     result;
    bwwp_pkg::table_status_t status;

    // Execute the held request when the result register can take it
    assign advance = item_valid && room;

    bwwp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bwwp_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (advance),
        .item    (item),
        .result  (result),
        .status  (status)
    );

    bwwp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_item (result),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    `ASSERT_NEVER(a_count_bound, int'(status.count) > bwwp_pkg::WATCH_SLOTS, "entry count above table size")
    `ASSERT_PROP(a_exec_to_out, (item_valid && !m_valid) |=> m_valid, "held request produced no result")
    `ASSERT_NEVER(a_result_kinds, m_valid && m_item.hit && (m_item.entry_valid || m_item.set_rejected), "mixed result kinds")

endmodule

[verif/bus_write_watchpoint_unit_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus write watchpoint unit testbench
// Sends request beats into the watchpoint core with random gaps and result
// back-pressure. A local watchpoint table predicts results not typed into
// directed rows; every result beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module bus_write_watchpoint_unit_core_tb;

    localparam logic [2:0] REQ_RESERVED = 3'd7;
    localparam int TOTAL_BEATS  = 1650;
    localparam int MAX_IDLE     = 18;
    localparam int HOLD_CYCLES  = 250;
    localparam int POOL_SIZE    = 12;
    localparam int DRAIN_CYCLES = 20;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bwwp_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bwwp_pkg::out_item_t m_item;

    int err_cnt = 0;

    // Local copy of the watchpoint table and the instruction frame
    bwwp_pkg::entry_t watch_tbl [bwwp_pkg::WATCH_SLOTS];
    int unsigned      watch_cnt = 0;
    logic [15:0]      cur_pc    = '0;
    logic             pend_hit  = 1'b0;
    logic [15:0]      pend_base = '0;

    bwwp_pkg::out_item_t watch_result_q [$];
    bwwp_pkg::in_item_t  stim_q [$];
    logic [15:0]         base_pool [POOL_SIZE];

    // Directed rows: request, whether the result is typed in, typed result
    bwwp_pkg::in_item_t  dir_reqs [$];
    bit                  dir_typed [$];
    bwwp_pkg::out_item_t dir_results [$];

    bus_write_watchpoint_unit_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Remove every entry with this base and close up the rest
    function automatic void watch_drop(logic [15:0] base);
        int unsigned wr;
        wr = 0;
        for (int rd = 0; rd < watch_cnt; rd++) begin
            if (watch_tbl[rd].base != base) begin
                watch_tbl[wr] = watch_tbl[rd];
                wr++;
            end
        end
        for (int k = wr; k < bwwp_pkg::WATCH_SLOTS; k++) begin
            watch_tbl[k] = '0;
        end
        watch_cnt = wr;
    endfunction

    // Apply one request to the table and return the result it produces
    function automatic bwwp_pkg::out_item_t watch_apply(bwwp_pkg::in_item_t req);
        bwwp_pkg::out_item_t res;
        logic [16:0]         range_end;
        res = '0;
        case (req.req_type)
            bwwp_pkg::REQ_SET: begin
                if (req.length != 16'd0) begin
                    watch_drop(req.address);
                    if (watch_cnt >= bwwp_pkg::WATCH_SLOTS) begin
                        res.set_rejected = 1'b1;
                    end else begin
                        watch_tbl[watch_cnt]        = '0;
                        watch_tbl[watch_cnt].base   = req.address;
                        watch_tbl[watch_cnt].length = req.length;
                        watch_cnt++;
                    end
                end
            end
            bwwp_pkg::REQ_CLEAR: begin
                watch_drop(req.address);
            end
            bwwp_pkg::REQ_CLEAR_ALL: begin
                for (int k = 0; k < bwwp_pkg::WATCH_SLOTS; k++) begin
                    watch_tbl[k] = '0;
                end
                watch_cnt = 0;
            end
            bwwp_pkg::REQ_BUS_WRITE: begin
                // Range end is 17 bits wide, so a range never wraps
                for (int i = 0; i < watch_cnt; i++) begin
                    range_end = {1'b0, watch_tbl[i].base} + {1'b0, watch_tbl[i].length};
                    if (req.address >= watch_tbl[i].base
                        && {1'b0, req.address} < range_end) begin
                        watch_tbl[i].last_byte = req.data_value;
                        watch_tbl[i].last_pc   = cur_pc;
                        watch_tbl[i].fired     = 1'b1;
                        if (!pend_hit) begin
                            pend_hit  = 1'b1;
                            pend_base = watch_tbl[i].base;
                        end
                    end
                end
            end
            bwwp_pkg::REQ_INSTR_BEGIN: begin
                cur_pc    = req.pc_value;
                pend_hit  = 1'b0;
                pend_base = '0;
            end
            bwwp_pkg::REQ_INSTR_END: begin
                if (pend_hit) begin
                    res.hit           = 1'b1;
                    res.hit_base      = pend_base;
                    res.hit_writer_pc = cur_pc;
                end
            end
            bwwp_pkg::REQ_READ_SLOT: begin
                if (req.slot_index < watch_cnt) begin
                    res.entry_valid      = 1'b1;
                    res.entry_base       = watch_tbl[req.slot_index].base;
                    res.entry_length     = watch_tbl[req.slot_index].length;
                    res.entry_last_value = watch_tbl[req.slot_index].last_byte;
                    res.entry_last_pc    = watch_tbl[req.slot_index].last_pc;
                    res.entry_fired      = watch_tbl[req.slot_index].fired;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic bwwp_pkg::in_item_t mk_req(bwwp_pkg::req_type_t kind,
                                                  logic [15:0] addr,
                                                  logic [15:0] len, logic [7:0] data,
                                                  logic [15:0] pc, logic [2:0] idx);
        bwwp_pkg::in_item_t r;
        r.req_type   = kind;
        r.address    = addr;
        r.length     = len;
        r.data_value = data;
        r.pc_value   = pc;
        r.slot_index = idx;
        return r;
    endfunction

    // Random request of a given kind, every field filled with noise
    function automatic bwwp_pkg::in_item_t rand_req(bwwp_pkg::req_type_t kind);
        bwwp_pkg::in_item_t r;
        r.req_type   = kind;
        r.address    = 16'($urandom);
        r.length     = 16'($urandom);
        r.data_value = 8'($urandom);
        r.pc_value   = 16'($urandom);
        r.slot_index = 3'($urandom);
        return r;
    endfunction

    // Bus write, mostly just past a watched base so that ranges get hit
    function automatic bwwp_pkg::in_item_t rand_write();
        bwwp_pkg::in_item_t r;
        r = rand_req(bwwp_pkg::REQ_BUS_WRITE);
        if ($urandom_range(0, 4) != 0) begin
            r.address = base_pool[$urandom_range(0, POOL_SIZE - 1)]
                        + 16'($urandom_range(0, 40));
        end
        return r;
    endfunction

    task automatic add_row(bwwp_pkg::in_item_t req, bit typed, bwwp_pkg::out_item_t res);
        dir_reqs.insert(dir_reqs.size(), req);
        dir_typed.insert(dir_typed.size(), typed);
        dir_results.insert(dir_results.size(), res);
    endtask

    // Append one request to the random stimulus queue
    task automatic stim_add(bwwp_pkg::in_item_t r);
        stim_q.insert(stim_q.size(), r);
    endtask

    // Queue the next random sequence: mostly whole instruction frames
    task automatic queue_random_burst();
        bwwp_pkg::in_item_t r;
        int                 pick;
        int                 len_pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            stim_add(rand_req(bwwp_pkg::REQ_INSTR_BEGIN));
            repeat ($urandom_range(0, 4)) stim_add(rand_write());
            stim_add(rand_req(bwwp_pkg::REQ_INSTR_END));
        end else if (pick < 63) begin
            stim_add(rand_write());
        end else if (pick < 83) begin
            r = rand_req(bwwp_pkg::REQ_SET);
            if ($urandom_range(0, 6) != 0) begin
                r.address = base_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            len_pick = $urandom_range(0, 19);
            if (len_pick == 0) begin
                r.length = 16'd0;
            end else if (len_pick == 1) begin
                r.length = 16'hFFFF;
            end else if (len_pick > 3) begin
                r.length = 16'($urandom_range(1, 48));
            end
            stim_add(r);
        end else if (pick < 88) begin
            r = rand_req(bwwp_pkg::REQ_CLEAR);
            if ($urandom_range(0, 4) != 0) begin
                r.address = base_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            stim_add(r);
        end else if (pick < 96) begin
            stim_add(rand_req(bwwp_pkg::REQ_READ_SLOT));
        end else if (pick < 97) begin
            stim_add(rand_req(bwwp_pkg::REQ_INSTR_END));
        end else if (pick < 98) begin
            stim_add(rand_req(bwwp_pkg::REQ_INSTR_BEGIN));
        end else if (pick < 99) begin
            stim_add(rand_req(bwwp_pkg::REQ_CLEAR_ALL));
        end else begin
            stim_add(rand_req(bwwp_pkg::req_type_t'(REQ_RESERVED)));
        end
    endtask

    // Compare one result field, four-state
    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Request side: reset, directed table, then random sequences
    initial begin : drive_requests
        bwwp_pkg::in_item_t  req;
        bwwp_pkg::out_item_t res;
        bwwp_pkg::out_item_t hit_rpt;
        bwwp_pkg::out_item_t reject_rpt;
        int                  gap;
        int                  sent;
        bit                  calm;

        for (int k = 0; k < bwwp_pkg::WATCH_SLOTS; k++) begin
            watch_tbl[k] = '0;
        end
        base_pool[0] = 16'h0000;
        base_pool[1] = 16'hFFFF;
        base_pool[2] = 16'hFFF0;
        for (int k = 3; k < POOL_SIZE; k++) begin
            base_pool[k] = 16'($urandom);
        end

        hit_rpt               = '0;
        hit_rpt.hit           = 1'b1;
        hit_rpt.hit_base      = 16'h0000;
        hit_rpt.hit_writer_pc = 16'hFFFF;
        reject_rpt              = '0;
        reject_rpt.set_rejected = 1'b1;

        // Empty table right after reset
        add_row(mk_req(bwwp_pkg::REQ_READ_SLOT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b1, '0);
        add_row(mk_req(bwwp_pkg::REQ_INSTR_END, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b1, '0);
        add_row(mk_req(bwwp_pkg::REQ_SET, 16'h0000, 16'h0010, 8'h00, 16'h0000, 3'd0),
                1'b1, '0);
        // Write before any instruction begin lands on pc zero
        add_row(mk_req(bwwp_pkg::REQ_BUS_WRITE, 16'h0000, 16'h0000, 8'h5A, 16'h0000, 3'd0),
                1'b1, '0);
        // Range at the top of the map, no wrap to low addresses
        add_row(mk_req(bwwp_pkg::REQ_SET, 16'hFFF0, 16'hFFFF, 8'h00, 16'h0000, 3'd0),
                1'b1, '0);
        // Zero length set is dropped
        add_row(mk_req(bwwp_pkg::REQ_SET, 16'h1000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b1, '0);
        add_row(mk_req(bwwp_pkg::REQ_INSTR_BEGIN, 16'h0000, 16'h0000, 8'h00, 16'hFFFF, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_BUS_WRITE, 16'h0005, 16'h0000, 8'hFF, 16'h0000, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_BUS_WRITE, 16'hFFFF, 16'hFFFF, 8'hA5, 16'h0000, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_INSTR_END, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b1, hit_rpt);
        add_row(mk_req(bwwp_pkg::REQ_READ_SLOT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b0, '0);
        // Re-set of an existing base moves it to the end, fired cleared
        add_row(mk_req(bwwp_pkg::REQ_SET, 16'h0000, 16'h0030, 8'h00, 16'h0000, 3'd0),
                1'b0, '0);
        for (int k = 1; k <= bwwp_pkg::WATCH_SLOTS - 2; k++) begin
            add_row(mk_req(bwwp_pkg::REQ_SET, 16'(k * 256), 16'h0020, 8'h00, 16'h0000, 3'd0),
                    1'b0, '0);
        end
        // New base on a full table is refused
        add_row(mk_req(bwwp_pkg::REQ_SET, 16'h7777, 16'h0008, 8'h00, 16'h0000, 3'd0),
                1'b1, reject_rpt);
        add_row(mk_req(bwwp_pkg::REQ_SET, 16'h0100, 16'h0040, 8'h00, 16'h0000, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_CLEAR, 16'h4321, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_READ_SLOT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd7),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::REQ_CLEAR_ALL, 16'h0000, 16'h0000, 8'h00, 16'h0000, 3'd0),
                1'b0, '0);
        add_row(mk_req(bwwp_pkg::req_type_t'(REQ_RESERVED), 16'hFFFF, 16'hFFFF, 8'hFF,
                       16'hFFFF, 3'd7),
                1'b1, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        sent = 0;
        calm = 1'b0;
        while (sent < TOTAL_BEATS) begin
            if (sent < dir_reqs.size()) begin
                req = dir_reqs[sent];
            end else begin
                if (stim_q.size() == 0) queue_random_burst();
                req = stim_q.pop_front();
            end
            // Alternate stretches of back-to-back beats with random gaps
            if (sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_item  <= req;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            res = watch_apply(req);
            if (sent < dir_reqs.size() && dir_typed[sent]) begin
                watch_result_q.insert(watch_result_q.size(), dir_results[sent]);
            end else begin
                watch_result_q.insert(watch_result_q.size(), res);
            end
            sent++;
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (watch_result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: random stalls per beat, two long hold-offs
    initial begin : accept_results
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            if (taken == 300 || taken == 1100) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge aclk) begin : check_results
        bwwp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (watch_result_q.size() == 0) begin
                $error("result beat with no request outstanding");
                err_cnt++;
            end else begin
                want = watch_result_q.pop_front();
                cmp_field("hit", 16'(want.hit), 16'(m_item.hit));
                cmp_field("hit_base", want.hit_base, m_item.hit_base);
                cmp_field("hit_writer_pc", want.hit_writer_pc, m_item.hit_writer_pc);
                cmp_field("set_rejected", 16'(want.set_rejected), 16'(m_item.set_rejected));
                cmp_field("entry_valid", 16'(want.entry_valid), 16'(m_item.entry_valid));
                cmp_field("entry_base", want.entry_base, m_item.entry_base);
                cmp_field("entry_length", want.entry_length, m_item.entry_length);
                cmp_field("entry_last_value", 16'(want.entry_last_value),
                          16'(m_item.entry_last_value));
                cmp_field("entry_last_pc", want.entry_last_pc, m_item.entry_last_pc);
                cmp_field("entry_fired", 16'(want.entry_fired), 16'(m_item.entry_fired));
            end
        end
    end

    // End a hung run
    initial begin : run_limit
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
